@@ rtl/urr_pkg.sv @@
// Shared types, widths and helpers for the unbiased range reduction pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package urr_pkg;

  localparam int WORD_BITS = 32;
  localparam int IN_WORD_BITS = 32;
  localparam int BOUND_BITS = 32;
  localparam int REM_BITS = 31;
  localparam int CMP_BITS = (WORD_BITS > REM_BITS) ? WORD_BITS : REM_BITS;
  localparam int IN_DATA_BITS = 64;
  localparam int OUT_DATA_BITS = 40;

  typedef enum logic [1:0] {
    ST_ACCEPT   = 2'd0,
    ST_REJECT   = 2'd1,
    ST_BADBOUND = 2'd2
  } urr_status_t;

  // One item in flight: the masked word, divisor, error flag and the two
  // partial remainders (word mod bound and all-ones mod bound).
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [REM_BITS-1:0]  div;
    logic                 bad;
    logic [REM_BITS-1:0]  rem_w;
    logic [REM_BITS-1:0]  rem_o;
  } urr_item_t;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  function automatic logic [REM_BITS-1:0] div_step(logic [REM_BITS-1:0] rem,
                                                   logic bit_in,
                                                   logic [REM_BITS-1:0] d);
    logic [REM_BITS:0] shifted;
    logic [REM_BITS:0] diff;
    shifted = {rem, bit_in};
    diff = shifted - {1'b0, d};
    if (shifted >= {1'b0, d}) begin
      return diff[REM_BITS-1:0];
    end
    return shifted[REM_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/urr_step.sv @@
// One pipeline stage of the dual restoring divider: a single quotient step
// for both remainder lanes. Depends on urr_pkg.
`default_nettype none

module urr_step
  import urr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire urr_item_t item_i,
  input  wire logic      bit_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output urr_item_t      item_o
);

  logic      valid_r;
  urr_item_t item_r;
  urr_item_t item_nxt;

  // Advance when this stage is empty or its contents move on.
  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign item_o  = item_r;

  always_comb begin
    item_nxt = item_i;
    item_nxt.rem_w = div_step(item_i.rem_w, bit_i, item_i.div);
    item_nxt.rem_o = div_step(item_i.rem_o, 1'b1, item_i.div);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/urr_result.sv @@
// Final stage: threshold compare, status encoding and the output register.
// Depends on urr_pkg.
`default_nettype none

module urr_result
  import urr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         valid_i,
  output logic              ready_o,
  input  wire urr_item_t    item_i,
  output logic              out_valid,
  input  wire logic         out_ready,
  output urr_status_t       status_o,
  output logic [REM_BITS-1:0] value_o
);

  localparam logic [CMP_BITS-1:0] ONES = CMP_BITS'({WORD_BITS{1'b1}});

  logic                valid_r;
  urr_status_t         status_r;
  urr_status_t         status_nxt;
  logic [REM_BITS-1:0] value_r;
  logic [REM_BITS-1:0] value_nxt;
  logic [CMP_BITS-1:0] threshold;
  logic [CMP_BITS-1:0] word_ext;

  assign ready_o   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign status_o  = status_r;
  assign value_o   = value_r;

  always_comb begin
    threshold = ONES - CMP_BITS'(item_i.rem_o);
    word_ext  = CMP_BITS'(item_i.word);
    value_nxt = '0;
    priority if (item_i.bad) begin
      status_nxt = ST_BADBOUND;
    end else if (word_ext < threshold) begin
      status_nxt = ST_ACCEPT;
      value_nxt  = item_i.rem_w;
    end else begin
      status_nxt = ST_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_i && !item_i.bad) |-> (item_i.rem_w < item_i.div && item_i.rem_o < item_i.div))
    else $error("remainder not below bound");

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r != ST_ACCEPT) |-> (value_r == '0))
    else $error("nonzero value on reject or bad bound");

  a_load_status: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_o && valid_i && item_i.bad) |=> (valid_r && status_r == ST_BADBOUND))
    else $error("bad bound not reported");

endmodule

`default_nettype wire

@@ rtl/unbiased_range_reduction_top.sv @@
// Top level: input register, WORD_BITS divider stages and the result stage.
// Depends on urr_pkg, urr_step and urr_result.
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready   in_tdata: random_word[31:0], bound[63:32]
//  out_     out  out_tvalid / out_tready out_tdata: status[1:0], value[32:2], 0[39:33]
//
// One item enters per cycle unless out_tready holds a full pipe; each stage performs
// one restoring-division step for each of the two remainders.
// Reset (rst_n low, synchronous) clears every stage valid bit; data is not reset.
// A stall on out_tready holds the output register; upstream stages keep
// filling empty slots, so in_tready drops only once the pipe is full.
`default_nettype none

module unbiased_range_reduction_top
  import urr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [IN_DATA_BITS-1:0]  in_tdata,   // random_word[31:0], bound[63:32]
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0]      out_tdata   // status[1:0], value[32:2], zero pad
);

  logic [IN_WORD_BITS-1:0] in_word;
  logic [BOUND_BITS-1:0]   in_bound;
  logic [WORD_BITS-1:0]    word_in;

  logic                    valid_r;
  urr_item_t               item_r;
  urr_item_t               item_nxt;

  urr_item_t               item_s  [WORD_BITS+1];
  logic                    valid_s [WORD_BITS+1];
  logic                    ready_s [WORD_BITS+1];
  logic                    res_ready;

  urr_status_t             status;
  logic [REM_BITS-1:0]     value;

  assign in_word  = in_tdata[IN_WORD_BITS-1:0];
  assign in_bound = in_tdata[IN_WORD_BITS +: BOUND_BITS];

  // Keep only the low WORD_BITS bits of the raw word.
  always_comb begin
    word_in = '0;
    for (int i = 0; i < WORD_BITS && i < IN_WORD_BITS; i++) begin
      word_in[i] = in_word[i];
    end
  end

  always_comb begin
    item_nxt.word  = word_in;
    item_nxt.div   = in_bound[REM_BITS-1:0];
    item_nxt.bad   = in_bound[BOUND_BITS-1] || (in_bound == '0);
    item_nxt.rem_w = '0;
    item_nxt.rem_o = '0;
  end

  assign in_tready = !valid_r || ready_s[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

  assign item_s[0]  = item_r;
  assign valid_s[0] = valid_r;

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
    urr_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .item_i  (item_s[k]),
      .bit_i   (item_s[k].word[WORD_BITS-1-k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .item_o  (item_s[k+1])
    );
  end

  assign ready_s[WORD_BITS] = res_ready;

  urr_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (valid_s[WORD_BITS]),
    .ready_o   (res_ready),
    .item_i    (item_s[WORD_BITS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status_o  (status),
    .value_o   (value)
  );

  assign out_tdata = {(OUT_DATA_BITS-2-REM_BITS)'(0), value, status};

endmodule

`default_nettype wire

@@ verif/unbiased_range_reduction_top_test.sv @@
// Self-checking testbench for unbiased_range_reduction_top: streams word/bound
// pairs under random idling and back-pressure, and predicts each result.
// Depends on urr_pkg and the unbiased_range_reduction_top RTL.
`default_nettype none

module unbiased_range_reduction_top_test;
  import urr_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = WORD_BITS + 8;
  localparam int MAX_RETRIES = 8;

  typedef struct packed {
    urr_status_t          status;
    logic [REM_BITS-1:0]  value;
  } reduction_t;

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata  = '0;   // random_word[31:0], bound[63:32]
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;        // status[1:0], value[32:2], zero pad

  reduction_t pending_results[$];
  int  errors;
  int  idle_cycles;
  int  n_accept;
  int  n_reject;
  int  n_badbound;
  int  n_sent;
  bit  tx_idle_en = 1'b1;
  bit  rx_idle_en = 1'b1;
  bit  hold_req   = 1'b0;

  unbiased_range_reduction_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] word_ones();
    return (64'd1 << WORD_BITS) - 64'd1;
  endfunction

  // Lowest word of the rejected top region for a positive bound.
  function automatic logic [IN_WORD_BITS-1:0] top_threshold(logic [BOUND_BITS-1:0] bound);
    logic [63:0] ones;
    logic [63:0] thr;
    ones = word_ones();
    thr = ones - (ones % {32'd0, bound});
    return thr[IN_WORD_BITS-1:0];
  endfunction

  function automatic reduction_t reduce_word(logic [IN_WORD_BITS-1:0] word,
                                             logic [BOUND_BITS-1:0] bound);
    reduction_t  r;
    logic [63:0] ones;
    logic [63:0] w;
    logic [63:0] b;
    logic [63:0] thr;
    logic [63:0] rem;
    ones = word_ones();
    w = {32'd0, word} & ones;
    b = {32'd0, bound};
    r.status = ST_BADBOUND;
    r.value = '0;
    if (!bound[BOUND_BITS-1] && bound != '0) begin
      thr = ones - (ones % b);
      if (w < thr) begin
        rem = w % b;
        r.status = ST_ACCEPT;
        r.value = rem[REM_BITS-1:0];
      end else begin
        r.status = ST_REJECT;
      end
    end
    return r;
  endfunction

  function automatic logic [BOUND_BITS-1:0] pick_bound();
    logic [BOUND_BITS-1:0] b;
    case ($urandom_range(0, 9))
      0: b = $urandom | 32'h8000_0000;
      1: b = 32'd1 << $urandom_range(0, 30);
      2, 3: b = $urandom_range(1, 64);
      4: b = $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
      5: b = 32'h7FFF_FFFF - $urandom_range(0, 3);
      9: b = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(65, 65535);
      default: b = $urandom & 32'h7FFF_FFFF;
    endcase
    return b;
  endfunction

  // Aim some words at the rejected region and at its lower edge.
  function automatic logic [IN_WORD_BITS-1:0] pick_word(logic [BOUND_BITS-1:0] bound);
    logic [IN_WORD_BITS-1:0] thr;
    logic [IN_WORD_BITS-1:0] w;
    w = $urandom;
    if (!bound[BOUND_BITS-1] && bound != '0) begin
      thr = top_threshold(bound);
      case ($urandom_range(0, 7))
        0: w = thr + $urandom_range(0, 32'hFFFF_FFFF - thr);
        1: w = thr - 32'd1 - $urandom_range(0, 3);
        default: w = $urandom;
      endcase
    end
    return w;
  endfunction

  task automatic send_item(input logic [IN_WORD_BITS-1:0] word,
                           input logic [BOUND_BITS-1:0] bound);
    int gap;
    in_tdata  <= {bound, word};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(reduce_word(word, bound));
    n_sent++;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_bad_bounds();
    send_item($urandom, 32'd0);
    send_item(32'hFFFF_FFFF, 32'h8000_0000);
    send_item(32'd0, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, $urandom | 32'h8000_0000);
  endtask

  // Probe just below the threshold, at it and at all-ones; powers of two
  // also reject a full block at the top.
  task automatic test_reject_edges();
    logic [BOUND_BITS-1:0] bounds[6];
    logic [IN_WORD_BITS-1:0] thr;
    bounds = '{32'd1, 32'd2, 32'd3, 32'h4000_0000, 32'h4000_0001, 32'h7FFF_FFFF};
    foreach (bounds[i]) begin
      thr = top_threshold(bounds[i]);
      send_item(thr - 32'd1, bounds[i]);
      send_item(thr, bounds[i]);
      send_item(32'hFFFF_FFFF, bounds[i]);
    end
  endtask

  task automatic test_field_extremes();
    send_item(32'd0, 32'd1);
    send_item(32'd0, 32'h7FFF_FFFF);
  endtask

  // Keep the bound and draw a fresh word after each rejection; abandon a few
  // retry chains early to mix in broken sequences.
  task automatic test_retry_sequences(input int count);
    int                      n;
    int                      tries;
    bit                      retry;
    logic [BOUND_BITS-1:0]   b;
    logic [IN_WORD_BITS-1:0] w;
    reduction_t              pred;
    n = 0;
    while (n < count) begin
      b = pick_bound();
      tries = 0;
      retry = 1'b1;
      while (retry) begin
        w = pick_word(b);
        send_item(w, b);
        n++;
        tries++;
        pred = reduce_word(w, b);
        retry = (pred.status == ST_REJECT) && (tries < MAX_RETRIES) &&
                ($urandom_range(0, 9) != 0);
      end
    end
  endtask

  // Hold the output while the sender keeps pushing, so the pipe fills up.
  task automatic test_output_holdoff(input int count);
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (count) send_item(pick_word(32'h0000_1000), pick_bound());
    stop_input();
    wait_for_results();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause(input int count);
    test_retry_sequences(count);
    stop_input();
    wait_for_results();
    test_retry_sequences(count);
  endtask

  task automatic test_full_rate(input int count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_retry_sequences(count);
    stop_input();
  endtask

  initial begin : receiver
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    reduction_t          want;
    urr_status_t         got_status;
    logic [REM_BITS-1:0] got_value;
    if (rst_n && out_tvalid && out_tready) begin
      got_status = urr_status_t'(out_tdata[1:0]);
      got_value  = out_tdata[REM_BITS+1:2];
      case (got_status)
        ST_ACCEPT:   n_accept++;
        ST_REJECT:   n_reject++;
        ST_BADBOUND: n_badbound++;
        default: ;
      endcase
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: status %0d value %0d", got_status, got_value);
        end
      end else begin
        want = pending_results.pop_front();
        if (want.status != got_status || want.value != got_value) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected status %0d value %0d, got status %0d value %0d",
                     want.status, want.value, got_status, got_value);
          end
        end
      end
    end
  end

  // Abort when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    n_accept = 0;
    n_reject = 0;
    n_badbound = 0;
    n_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bad_bounds();
    test_reject_edges();
    test_field_extremes();
    test_retry_sequences(1250);
    test_output_holdoff(100);
    test_drain_pause(40);
    test_full_rate(250);

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0d results never arrived", pending_results.size());
    end

    $display("Sent %0d words: %0d reduced, %0d rejected for retry, %0d with a bad bound",
             n_sent, n_accept, n_reject, n_badbound);
    $display("Run included an output hold-off, a full drain pause and full-rate streaming");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ unbiased_range_reduction_top.f @@
rtl/urr_pkg.sv
rtl/urr_step.sv
rtl/urr_result.sv
rtl/unbiased_range_reduction_top.sv
verif/unbiased_range_reduction_top_test.sv
